FILE: src/ddarwd_pkg.sv
package ddarwd_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int MAP_BITS       = 6;
    localparam int CELL_AW        = 2 * MAP_BITS;
    localparam int CELL_COUNT     = 1 << CELL_AW;
    localparam int WALL_W         = 8;
    localparam int SCREEN_COLUMNS = 640;
    localparam int SCREEN_ROWS    = 480;
    localparam int ROW_HALF       = SCREEN_ROWS / 2;
    localparam int COL_W          = 10;

    localparam int POS_W     = 22;
    localparam int VEC_W     = 18;
    localparam int RAY_W     = 22;
    localparam int CAM_W     = 19;
    localparam int CAM_SHIFT = 12;
    localparam int CAM_RECIP_W = 20;
    localparam int CAM_RECIP = ((1 << (FRAC_BITS + 1 + CAM_SHIFT)) + SCREEN_COLUMNS - 1)
                               / SCREEN_COLUMNS;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int MUL_A_W   = 19;
    localparam int MUL_B_W   = 34;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DELTA_CAP_LOG = 38;
    localparam int DELTA_W   = DELTA_CAP_LOG + 1;
    localparam int SD_W      = 48;
    localparam int MC_W      = 8;
    localparam int NUM_W     = 25;
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = 6;
    localparam int PERP_W    = 24;
    localparam int LH_W      = 16;
    localparam int ROW_W     = 9;
    localparam int HALF_W    = LH_W - 1;
    localparam int OUT_W     = 72;

    localparam int IN_W      = 32;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic signed [VEC_W-1:0] DIR_X_RESET   = 18'sd65535;
    localparam logic signed [VEC_W-1:0] PLANE_Y_RESET = 18'sd43253;

    typedef enum logic [2:0] {
        REG_POS_X,
        REG_POS_Y,
        REG_DIR_X,
        REG_DIR_Y,
        REG_PLANE_X,
        REG_PLANE_Y
    } reg_idx_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_ACCEPT,
        CMD_CAM,
        CMD_MUL_X,
        CMD_MUL_Y,
        CMD_RAY_Y,
        CMD_DX_DIV,
        CMD_DY_DIV,
        CMD_SD_X,
        CMD_SD_Y,
        CMD_SD_END,
        CMD_STEP,
        CMD_CHECK,
        CMD_PERP_DIV,
        CMD_PERP_END,
        CMD_LH_DIV,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic clear_last;
        logic outside;
        logic cell_hit;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [VEC_W-1:0] dir_x;
        logic signed [VEC_W-1:0] dir_y;
        logic signed [VEC_W-1:0] plane_x;
        logic signed [VEC_W-1:0] plane_y;
    } cfg_t;

endpackage

FILE: src/ddarwd_ram.sv
module ddarwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ddarwd_div.sv
module ddarwd_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [ddarwd_pkg::DIV_NUM_W-1:0] num,
    input  logic [ddarwd_pkg::DIV_DEN_W-1:0] den,
    output logic                            done,
    output logic [ddarwd_pkg::DIV_NUM_W-1:0] quo
);
    import ddarwd_pkg::*;

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic                 last;

    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};
    assign last    = cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: src/ddarwd_ctrl.sv
module ddarwd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   in_func,
    output logic                   s_tready,
    input  ddarwd_pkg::dp_status_t status,
    output ddarwd_pkg::cmd_t       cmd
);
    import ddarwd_pkg::*;

    typedef enum logic [19:0] {
        ST_CLEAR     = 20'h00001,
        ST_IDLE      = 20'h00002,
        ST_CAM       = 20'h00004,
        ST_MUL_X     = 20'h00008,
        ST_MUL_Y     = 20'h00010,
        ST_RAY_Y     = 20'h00020,
        ST_DX_DIV    = 20'h00040,
        ST_DX_WAIT   = 20'h00080,
        ST_DY_DIV    = 20'h00100,
        ST_DY_WAIT   = 20'h00200,
        ST_SD_X      = 20'h00400,
        ST_SD_Y      = 20'h00800,
        ST_SD_END    = 20'h01000,
        ST_STEP      = 20'h02000,
        ST_CHECK     = 20'h04000,
        ST_PERP_DIV  = 20'h08000,
        ST_PERP_WAIT = 20'h10000,
        ST_PERP_END  = 20'h20000,
        ST_LH_DIV    = 20'h40000,
        ST_LH_WAIT   = 20'h80000,
        ST_FINISH    = 20'h00000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        case (state_reg)
            ST_CLEAR: begin
                cmd = CMD_CLEAR;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd = CMD_ACCEPT;
                    if (in_func) begin
                        state_next = ST_CAM;
                    end
                end
            end
            ST_CAM: begin
                cmd        = CMD_CAM;
                state_next = ST_MUL_X;
            end
            ST_MUL_X: begin
                cmd        = CMD_MUL_X;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                cmd        = CMD_MUL_Y;
                state_next = ST_RAY_Y;
            end
            ST_RAY_Y: begin
                cmd        = CMD_RAY_Y;
                state_next = ST_DX_DIV;
            end
            ST_DX_DIV: begin
                cmd        = CMD_DX_DIV;
                state_next = ST_DX_WAIT;
            end
            ST_DX_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_DY_DIV;
                end
            end
            ST_DY_DIV: begin
                cmd        = CMD_DY_DIV;
                state_next = ST_DY_WAIT;
            end
            ST_DY_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_SD_X;
                end
            end
            ST_SD_X: begin
                cmd        = CMD_SD_X;
                state_next = ST_SD_Y;
            end
            ST_SD_Y: begin
                cmd        = CMD_SD_Y;
                state_next = ST_SD_END;
            end
            ST_SD_END: begin
                cmd        = CMD_SD_END;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd        = CMD_STEP;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd = CMD_CHECK;
                if (status.outside || status.cell_hit) begin
                    state_next = ST_PERP_DIV;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_PERP_DIV: begin
                cmd        = CMD_PERP_DIV;
                state_next = ST_PERP_WAIT;
            end
            ST_PERP_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_PERP_END;
                end
            end
            ST_PERP_END: begin
                cmd        = CMD_PERP_END;
                state_next = ST_LH_DIV;
            end
            ST_LH_DIV: begin
                cmd        = CMD_LH_DIV;
                state_next = ST_LH_WAIT;
            end
            ST_LH_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd = CMD_FINISH;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: src/ddarwd_dp.sv
module ddarwd_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ddarwd_pkg::cmd_t              cmd,
    input  ddarwd_pkg::cfg_t              cfg,
    input  logic                          in_func,
    input  logic [ddarwd_pkg::COL_W-1:0]    in_column,
    input  logic [ddarwd_pkg::MAP_BITS-1:0] in_cell_x,
    input  logic [ddarwd_pkg::MAP_BITS-1:0] in_cell_y,
    input  logic [ddarwd_pkg::WALL_W-1:0]   in_cell_value,
    output ddarwd_pkg::dp_status_t        status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ddarwd_pkg::OUT_W-1:0]  m_tdata
);
    import ddarwd_pkg::*;

    localparam logic [DELTA_W-1:0] DELTA_CAP = DELTA_W'(1) << DELTA_CAP_LOG;
    localparam logic [PERP_W-1:0]  PERP_MAX  = '1;
    localparam logic [LH_W-1:0]    LH_MAX    = '1;

    logic [COL_W-1:0]          column_reg;
    logic signed [CAM_W-1:0]   cam_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [RAY_W-1:0]   rx_reg, ry_reg;
    logic [DELTA_W-1:0]        dx_reg, dy_reg;
    logic [SD_W-1:0]           sdx_reg, sdy_reg;
    logic signed [MC_W-1:0]    mx_reg, my_reg;
    logic                      side_reg;
    logic                      esc_reg;
    logic [PERP_W-1:0]         perp_reg;
    logic [CELL_AW-1:0]        clear_cnt_reg;
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;

    logic                      div_start, div_done;
    logic [DIV_NUM_W-1:0]      div_num, div_q;
    logic [DIV_DEN_W-1:0]      div_den;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  product;

    logic                      ram_we;
    logic [CELL_AW-1:0]        ram_waddr, ram_raddr;
    logic [WALL_W-1:0]         ram_wdata, ram_rdata;

    logic [COL_W+CAM_RECIP_W-1:0] cam_prod;
    logic [RAY_W-1:0]          ray_next;
    logic                      rx_neg, ry_neg, rx_zero, ry_zero;
    logic [RAY_W-1:0]          rx_mag, ry_mag;
    logic [FRAC_W-1:0]         fx, fy;
    logic signed [MC_W-1:0]    mx_step, my_step;
    logic                      lt;
    logic                      out_free;

    logic signed [MC_W-1:0]    p_cell;
    logic [POS_W-1:0]          p_pos;
    logic                      p_neg, p_zero;
    logic [RAY_W-1:0]          p_r_mag;
    logic [NUM_W-1:0]          p_num, p_num_inv;
    logic                      p_num_neg;
    logic [PERP_W-1:0]         p_num_mag;
    logic [PERP_W-1:0]         perp_next;
    logic [LH_W-1:0]           lh_val;
    logic [HALF_W-1:0]         half;
    logic [ROW_W-1:0]          draw_start, draw_end;

    ddarwd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    ddarwd_ram #(
        .WIDTH (WALL_W),
        .DEPTH (CELL_COUNT)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // column * 2^(F+1) / SCREEN_COLUMNS by reciprocal multiply, exact over the column range
    assign cam_prod = column_reg * CAM_RECIP_W'(CAM_RECIP);
    assign ray_next = prod_reg[FRAC_BITS+RAY_W-1:FRAC_BITS];

    assign rx_neg  = rx_reg[RAY_W-1];
    assign ry_neg  = ry_reg[RAY_W-1];
    assign rx_zero = rx_reg == '0;
    assign ry_zero = ry_reg == '0;
    assign rx_mag  = rx_neg ? RAY_W'(-rx_reg) : RAY_W'(rx_reg);
    assign ry_mag  = ry_neg ? RAY_W'(-ry_reg) : RAY_W'(ry_reg);

    assign fx = rx_neg ? FRAC_W'(cfg.pos_x[FRAC_BITS-1:0])
                       : FRAC_W'(1 << FRAC_BITS) - FRAC_W'(cfg.pos_x[FRAC_BITS-1:0]);
    assign fy = ry_neg ? FRAC_W'(cfg.pos_y[FRAC_BITS-1:0])
                       : FRAC_W'(1 << FRAC_BITS) - FRAC_W'(cfg.pos_y[FRAC_BITS-1:0]);

    assign mx_step = rx_neg ? mx_reg - MC_W'(1) : mx_reg + MC_W'(1);
    assign my_step = ry_neg ? my_reg - MC_W'(1) : my_reg + MC_W'(1);
    assign lt      = sdx_reg < sdy_reg;

    // Lookup address of the cell that the next step enters
    assign ram_raddr = lt ? {mx_step[MAP_BITS-1:0], my_reg[MAP_BITS-1:0]}
                          : {mx_reg[MAP_BITS-1:0], my_step[MAP_BITS-1:0]};

    assign ram_we    = (cmd == CMD_CLEAR) || (cmd == CMD_ACCEPT && !in_func);
    assign ram_waddr = (cmd == CMD_CLEAR) ? clear_cnt_reg : {in_cell_x, in_cell_y};
    assign ram_wdata = (cmd == CMD_CLEAR) ? '0 : in_cell_value;

    assign p_cell    = side_reg ? my_reg : mx_reg;
    assign p_pos     = side_reg ? cfg.pos_y : cfg.pos_x;
    assign p_neg     = side_reg ? ry_neg : rx_neg;
    assign p_zero    = side_reg ? ry_zero : rx_zero;
    assign p_r_mag   = side_reg ? ry_mag : rx_mag;
    assign p_num     = {p_cell[MC_W-1], p_cell, FRAC_BITS'(0)} - NUM_W'(p_pos)
                       + (p_neg ? NUM_W'(1 << FRAC_BITS) : NUM_W'(0));
    assign p_num_neg = p_num[NUM_W-1];
    assign p_num_inv = -p_num;
    assign p_num_mag = p_num_neg ? p_num_inv[PERP_W-1:0] : p_num[PERP_W-1:0];

    always_comb begin
        if (p_zero) begin
            perp_next = PERP_MAX;
        end else if (p_num != '0 && p_num_neg != p_neg) begin
            perp_next = '0;
        end else if (div_q > DIV_NUM_W'(PERP_MAX)) begin
            perp_next = PERP_MAX;
        end else begin
            perp_next = div_q[PERP_W-1:0];
        end
    end

    always_comb begin
        if (perp_reg == '0 || div_q > DIV_NUM_W'(LH_MAX)) begin
            lh_val = LH_MAX;
        end else begin
            lh_val = div_q[LH_W-1:0];
        end
    end

    assign half = lh_val[LH_W-1:1];
    assign draw_start = (half >= HALF_W'(ROW_HALF)) ? '0 : ROW_W'(HALF_W'(ROW_HALF) - half);
    assign draw_end   = (half >= HALF_W'(ROW_HALF)) ? ROW_W'(SCREEN_ROWS - 1)
                                                    : ROW_W'(HALF_W'(ROW_HALF) + half);

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (cmd)
            CMD_DX_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(1) << (2 * FRAC_BITS);
                div_den   = DIV_DEN_W'(rx_mag);
            end
            CMD_DY_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(1) << (2 * FRAC_BITS);
                div_den   = DIV_DEN_W'(ry_mag);
            end
            CMD_PERP_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(p_num_mag) << FRAC_BITS;
                div_den   = DIV_DEN_W'(p_r_mag);
            end
            CMD_LH_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(SCREEN_ROWS) << FRAC_BITS;
                div_den   = DIV_DEN_W'(perp_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            CMD_MUL_X: begin
                mul_a = cam_reg;
                mul_b = MUL_B_W'(cfg.plane_x);
            end
            CMD_MUL_Y: begin
                mul_a = cam_reg;
                mul_b = MUL_B_W'(cfg.plane_y);
            end
            CMD_SD_X: begin
                mul_a = $signed(MUL_A_W'(fx));
                mul_b = $signed(MUL_B_W'(dx_reg));
            end
            CMD_SD_Y: begin
                mul_a = $signed(MUL_A_W'(fy));
                mul_b = $signed(MUL_B_W'(dy_reg));
            end
            default: begin
            end
        endcase
    end

    assign product  = mul_a * mul_b;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd == CMD_CLEAR) begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (cmd == CMD_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_ACCEPT: begin
                column_reg <= in_column;
            end
            CMD_CAM: begin
                cam_reg <= $signed(CAM_W'(cam_prod >> CAM_SHIFT))
                           - $signed(CAM_W'(1 << FRAC_BITS));
            end
            CMD_MUL_X: begin
                prod_reg <= product;
            end
            CMD_MUL_Y: begin
                rx_reg   <= RAY_W'(cfg.dir_x) + ray_next;
                prod_reg <= product;
            end
            CMD_RAY_Y: begin
                ry_reg <= RAY_W'(cfg.dir_y) + ray_next;
            end
            CMD_DY_DIV: begin
                dx_reg <= rx_zero ? DELTA_CAP : DELTA_W'(div_q);
            end
            CMD_SD_X: begin
                dy_reg   <= ry_zero ? DELTA_CAP : DELTA_W'(div_q);
                prod_reg <= product;
                mx_reg   <= MC_W'(cfg.pos_x[POS_W-1:FRAC_BITS]);
                my_reg   <= MC_W'(cfg.pos_y[POS_W-1:FRAC_BITS]);
            end
            CMD_SD_Y: begin
                sdx_reg  <= rx_zero ? SD_W'(fx) << (DELTA_CAP_LOG - FRAC_BITS)
                                    : SD_W'(prod_reg[PROD_W-1:FRAC_BITS]);
                prod_reg <= product;
            end
            CMD_SD_END: begin
                sdy_reg <= ry_zero ? SD_W'(fy) << (DELTA_CAP_LOG - FRAC_BITS)
                                   : SD_W'(prod_reg[PROD_W-1:FRAC_BITS]);
            end
            CMD_STEP: begin
                if (lt) begin
                    sdx_reg  <= sdx_reg + SD_W'(dx_reg);
                    mx_reg   <= mx_step;
                    side_reg <= 1'b0;
                end else begin
                    sdy_reg  <= sdy_reg + SD_W'(dy_reg);
                    my_reg   <= my_step;
                    side_reg <= 1'b1;
                end
            end
            CMD_CHECK: begin
                esc_reg <= status.outside;
            end
            CMD_PERP_END: begin
                perp_reg <= perp_next;
            end
            CMD_FINISH: begin
                if (out_free) begin
                    m_tdata_reg <= {esc_reg, my_reg[MAP_BITS-1:0], mx_reg[MAP_BITS-1:0],
                                    side_reg, draw_end, draw_start, lh_val, perp_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign status.div_done   = div_done;
    assign status.clear_last = &clear_cnt_reg;
    assign status.outside    = (mx_reg[MC_W-1:MAP_BITS] != '0) ||
                               (my_reg[MC_W-1:MAP_BITS] != '0);
    assign status.cell_hit   = ram_rdata != '0;
    assign status.out_free   = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: src/dda_ray_wall_distance_unit.sv
// Grid ray caster. A write request (tuser 0) stores one 8-bit cell of the 64x64 map and
// returns nothing. A cast request (tuser 1) returns one result: fixed work of four passes
// through the single radix-2 divider (two ray deltas, wall distance, slice height) and the
// camera, multiply and setup states, plus a step and a check state per grid step, the check
// waiting on the registered map read. One request is in flight at a time; a finished result
// waits in the output register while the next request is taken. After reset the map is
// cleared to open cells in a pass over all 4096 cells during which no request is taken;
// camera registers can be written at any time the block is idle.
module dda_ray_wall_distance_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ddarwd_pkg::APB_AW-1:0] paddr,
    input  logic [ddarwd_pkg::APB_DW-1:0] pwdata,
    output logic [ddarwd_pkg::APB_DW-1:0] prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ddarwd_pkg::IN_W-1:0]   s_tdata,  // column, cell_x, cell_y, cell_value
    input  logic [0:0]                    s_tuser,  // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // perp_distance, line_height, draw_start, draw_end, wall_side, hit_x, hit_y, escaped
    output logic [ddarwd_pkg::OUT_W-1:0]  m_tdata
);
    import ddarwd_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       cmd;
    dp_status_t status;
    reg_idx_t   reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pos_x   <= '0;
            cfg_reg.pos_y   <= '0;
            cfg_reg.dir_x   <= DIR_X_RESET;
            cfg_reg.dir_y   <= '0;
            cfg_reg.plane_x <= '0;
            cfg_reg.plane_y <= PLANE_Y_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_POS_X:   cfg_reg.pos_x   <= pwdata[POS_W-1:0];
                REG_POS_Y:   cfg_reg.pos_y   <= pwdata[POS_W-1:0];
                REG_DIR_X:   cfg_reg.dir_x   <= pwdata[VEC_W-1:0];
                REG_DIR_Y:   cfg_reg.dir_y   <= pwdata[VEC_W-1:0];
                REG_PLANE_X: cfg_reg.plane_x <= pwdata[VEC_W-1:0];
                REG_PLANE_Y: cfg_reg.plane_y <= pwdata[VEC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POS_X:   prdata = APB_DW'(cfg_reg.pos_x);
            REG_POS_Y:   prdata = APB_DW'(cfg_reg.pos_y);
            REG_DIR_X:   prdata = APB_DW'(cfg_reg.dir_x);
            REG_DIR_Y:   prdata = APB_DW'(cfg_reg.dir_y);
            REG_PLANE_X: prdata = APB_DW'(cfg_reg.plane_x);
            REG_PLANE_Y: prdata = APB_DW'(cfg_reg.plane_y);
            default:     prdata = '0;
        endcase
    end

    ddarwd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_func  (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ddarwd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .in_func       (s_tuser[0]),
        .in_column     (s_tdata[9:0]),
        .in_cell_x     (s_tdata[15:10]),
        .in_cell_y     (s_tdata[21:16]),
        .in_cell_value (s_tdata[29:22]),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    a_cast_holds_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
        else $error("intake open during cast");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd == CMD_FINISH))
        else $error("result without finish");

    a_rows_bracket_center: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:40] <= ROW_W'(ROW_HALF) && m_tdata[57:49] >= ROW_W'(ROW_HALF)))
        else $error("draw rows off center");

endmodule
